// ----- design/mips_subset_instruction_step_macros.svh -----
// Assertion macros used by the top module of the instruction step core.
`ifndef MIPS_SUBSET_INSTRUCTION_STEP_MACROS_SVH
`define MIPS_SUBSET_INSTRUCTION_STEP_MACROS_SVH

`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define MSIS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
// The consequent must hold in the cycle after the antecedent.
`define MSIS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define MSIS_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define MSIS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- design/msis_pkg.sv -----
// Types, codes and constants of the MIPS subset instruction step core.
package msis_pkg;

    localparam int unsigned REG_COUNT_DEF = 32;
    localparam logic [31:0] WORD_BYTES    = 32'd4;

    // Instruction field positions.
    localparam int unsigned OPC_LSB = 26;
    localparam int unsigned RS_LSB  = 21;
    localparam int unsigned RT_LSB  = 16;
    localparam int unsigned RD_LSB  = 11;

    // Opcodes and function codes.
    localparam logic [5:0] OPC_RTYPE = 6'h00;
    localparam logic [5:0] OPC_J     = 6'h02;
    localparam logic [5:0] OPC_BEQ   = 6'h04;
    localparam logic [5:0] OPC_LW    = 6'h23;
    localparam logic [5:0] OPC_SW    = 6'h2B;
    localparam logic [5:0] FN_ADD    = 6'h20;

    // Item kinds.
    localparam logic OP_FETCH    = 1'b0;
    localparam logic OP_RESPONSE = 1'b1;

    // Memory request kinds; the pending access uses the same encoding.
    localparam logic [1:0] MEM_NONE  = 2'd0;
    localparam logic [1:0] MEM_LOAD  = 2'd1;
    localparam logic [1:0] MEM_STORE = 2'd2;

    // Fault codes.
    localparam logic [2:0] FAULT_NONE   = 3'd0;
    localparam logic [2:0] FAULT_FETCH  = 3'd1;
    localparam logic [2:0] FAULT_FUNCT  = 3'd2;
    localparam logic [2:0] FAULT_LOAD   = 3'd3;
    localparam logic [2:0] FAULT_STORE  = 3'd4;
    localparam logic [2:0] FAULT_OPCODE = 3'd5;

    typedef logic [4:0] t_reg_idx;

    typedef struct packed {
        logic        op;
        logic [31:0] data_word;
        logic        access_ok;
    } t_in_item;

    typedef struct packed {
        logic [31:0] next_fetch_addr;
        logic [1:0]  mem_kind;
        logic [31:0] mem_addr;
        logic [31:0] mem_wdata;
        logic        is_running;
        logic [2:0]  fault_code;
        logic [31:0] retired;
    } t_out_item;

    // Architectural state apart from the register file.
    typedef struct packed {
        logic [31:0] pc;
        logic        run;
        logic [31:0] retired;
        logic [1:0]  pend;
        t_reg_idx    pend_dest;
    } t_arch_state;

    // Register file write port.
    typedef struct packed {
        logic        en;
        t_reg_idx    addr;
        logic [31:0] data;
    } t_wb;

endpackage

// ----- design/mips_subset_instruction_step.sv -----
// Top level of the MIPS subset core that runs one fetched word or memory response per item.
//
// Usage: the input channel (i_in_valid, o_in_stall, i_in_item) carries either a fetched
// instruction word or a data memory response, told apart by the op field. The output
// channel (o_out_valid, i_out_stall, o_out_item) returns exactly one result item per
// input item: the next fetch address, any load or store request, the running flag, a
// fault code and the retired-instruction count.
// An accepted item is held in the input register and its result in the result register.
// Throughput is one item per cycle unless the receiver stalls: the input register reads
// both source registers, and the execute logic, the register file write and the result
// register complete as the item moves on; a same-cycle write is forwarded to the next item's read.
// When the receiver stalls, the result register holds, the input register fills behind
// it, and o_in_stall rises once both hold an item; nothing is dropped.
// Reset (synchronous, active low) clears the PC and the retired count, sets the running
// flag, drops any pending access and marks every register as reading zero at once.
// After a fault the core keeps answering every item, but ignores its content.
`include "mips_subset_instruction_step_macros.svh"

module mips_subset_instruction_step #(
    parameter int unsigned REG_COUNT = msis_pkg::REG_COUNT_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  msis_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output msis_pkg::t_out_item o_out_item
);
    import msis_pkg::*;

    localparam int unsigned IDX_W = $clog2(REG_COUNT);

    // Input register stage.
    logic        r_s1_vld;
    t_in_item    r_s1_item;
    // Output register stage.
    logic        r_out_vld;
    t_out_item   r_out_item;
    // Architectural state other than the register file.
    t_arch_state r_state;
    t_arch_state n_state;

    logic        in_acc;
    logic        out_free;
    logic        adv;
    t_wb         wb;
    t_wb         wb_gated;
    t_out_item   n_result;
    logic [31:0] rs_data;
    logic [31:0] rt_data;

    // The result register can take a new item when empty or when its item leaves now.
    assign out_free   = !r_out_vld || !i_out_stall;
    assign adv        = r_s1_vld && out_free;
    assign o_in_stall = r_s1_vld && !out_free;
    assign in_acc     = i_in_valid && !o_in_stall;

    // Register writes only take effect for the item that actually moves on.
    assign wb_gated = '{en: wb.en && adv, addr: wb.addr, data: wb.data};

    msis_regfile #(
        .REG_COUNT (REG_COUNT)
    ) u_regfile (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_acc),
        .i_rs_idx  (i_in_item.data_word[RS_LSB +: IDX_W]),
        .i_rt_idx  (i_in_item.data_word[RT_LSB +: IDX_W]),
        .i_wb      (wb_gated),
        .o_rs_data (rs_data),
        .o_rt_data (rt_data)
    );

    msis_exec u_exec (
        .i_item    (r_s1_item),
        .i_state   (r_state),
        .i_rs_data (rs_data),
        .i_rt_data (rt_data),
        .o_state   (n_state),
        .o_wb      (wb),
        .o_result  (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_state   <= '{pc: 32'd0, run: 1'b1, retired: 32'd0,
                           pend: MEM_NONE, pend_dest: '0};
        end else begin
            r_s1_vld  <= in_acc || (r_s1_vld && !adv);
            r_out_vld <= adv || (r_out_vld && i_out_stall);
            if (adv) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_item <= i_in_item;
        end
        if (adv) begin
            r_out_item <= n_result;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out_item;

    // A stopped core never starts again without a reset.
    `MSIS_ASSERT_NEXT(a_stop_sticks, i_clk, i_rst_n, !r_state.run, !r_state.run)
    // A reported fault always comes with the running flag cleared.
    `MSIS_ASSERT_SAME(a_fault_stops, i_clk, i_rst_n,
        r_out_vld && r_out_item.fault_code != FAULT_NONE, !r_out_item.is_running)
    // No request means zero address and zero store data.
    `MSIS_ASSERT_SAME(a_idle_request_zero, i_clk, i_rst_n,
        r_out_vld && r_out_item.mem_kind == MEM_NONE,
        r_out_item.mem_addr == 32'd0 && r_out_item.mem_wdata == 32'd0)
    // While an access is pending no instruction retires.
    `MSIS_ASSERT_NEXT(a_pending_no_retire, i_clk, i_rst_n,
        adv && r_state.pend != MEM_NONE, r_state.retired == $past(r_state.retired))

endmodule

// ----- design/msis_regfile.sv -----
// Register file with two registered read ports, write forwarding and reset-to-zero valid bits.
module msis_regfile #(
    parameter int unsigned REG_COUNT = msis_pkg::REG_COUNT_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_rd_en,
    input  logic [$clog2(REG_COUNT)-1:0] i_rs_idx,
    input  logic [$clog2(REG_COUNT)-1:0] i_rt_idx,
    input  msis_pkg::t_wb                i_wb,
    output logic [31:0]                  o_rs_data,
    output logic [31:0]                  o_rt_data
);
    import msis_pkg::*;

    localparam int unsigned IDX_W = $clog2(REG_COUNT);

    logic [31:0]          r_mem [REG_COUNT];
    logic [REG_COUNT-1:0] r_valid;
    logic [31:0]          r_rs_raw;
    logic [31:0]          r_rt_raw;
    logic                 r_rs_ok;
    logic                 r_rt_ok;
    logic                 r_rs_fwd;
    logic                 r_rt_fwd;
    logic [31:0]          r_wb_data;
    logic [IDX_W-1:0]     wb_idx;

    assign wb_idx = i_wb.addr[IDX_W-1:0];

    // An entry never written since reset reads as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wb.en) begin
            r_valid[wb_idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wb.en) begin
            r_mem[wb_idx] <= i_wb.data;
        end
    end

    // A write landing in the same cycle as the read is forwarded.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rs_raw  <= r_mem[i_rs_idx];
            r_rt_raw  <= r_mem[i_rt_idx];
            r_rs_ok   <= r_valid[i_rs_idx];
            r_rt_ok   <= r_valid[i_rt_idx];
            r_rs_fwd  <= i_wb.en && (wb_idx == i_rs_idx);
            r_rt_fwd  <= i_wb.en && (wb_idx == i_rt_idx);
            r_wb_data <= i_wb.data;
        end
    end

    assign o_rs_data = r_rs_fwd ? r_wb_data : (r_rs_ok ? r_rs_raw : 32'd0);
    assign o_rt_data = r_rt_fwd ? r_wb_data : (r_rt_ok ? r_rt_raw : 32'd0);

endmodule

// ----- design/msis_exec.sv -----
// Decode and execute of one item against the current architectural state.
module msis_exec (
    input  msis_pkg::t_in_item    i_item,
    input  msis_pkg::t_arch_state i_state,
    input  logic [31:0]           i_rs_data,
    input  logic [31:0]           i_rt_data,
    output msis_pkg::t_arch_state o_state,
    output msis_pkg::t_wb         o_wb,
    output msis_pkg::t_out_item   o_result
);
    import msis_pkg::*;

    logic [5:0]  opc;
    logic [5:0]  fn;
    t_reg_idx    rt;
    t_reg_idx    rd;
    logic [31:0] sx;
    logic [31:0] pc4;
    logic [31:0] br_target;
    logic [31:0] j_target;
    logic [31:0] ea;
    logic [31:0] sum;
    logic [1:0]  kind;
    logic [31:0] addr;
    logic [31:0] wdata;
    logic [2:0]  fault;

    assign opc       = i_item.data_word[OPC_LSB +: 6];
    assign fn        = i_item.data_word[5:0];
    assign rt        = i_item.data_word[RT_LSB +: 5];
    assign rd        = i_item.data_word[RD_LSB +: 5];
    assign sx        = {{16{i_item.data_word[15]}}, i_item.data_word[15:0]};
    assign pc4       = i_state.pc + WORD_BYTES;
    assign br_target = pc4 + {sx[29:0], 2'b00};
    assign j_target  = {pc4[31:28], i_item.data_word[25:0], 2'b00};
    assign ea        = i_rs_data + sx;
    assign sum       = i_rs_data + i_rt_data;

    always_comb begin
        o_state = i_state;
        o_wb    = '{en: 1'b0, addr: rt, data: i_item.data_word};
        kind    = MEM_NONE;
        addr    = 32'd0;
        wdata   = 32'd0;
        fault   = FAULT_NONE;
        priority if (i_state.run && i_item.op == OP_FETCH && i_state.pend == MEM_NONE) begin
            if (!i_item.access_ok) begin
                o_state.run = 1'b0;
                fault       = FAULT_FETCH;
            end else begin
                o_state.pc      = pc4;
                o_state.retired = i_state.retired + 32'd1;
                unique case (opc)
                    OPC_RTYPE: begin
                        if (fn == FN_ADD) begin
                            o_wb = '{en: 1'b1, addr: rd, data: sum};
                        end else begin
                            o_state.run = 1'b0;
                            fault       = FAULT_FUNCT;
                        end
                    end
                    OPC_LW: begin
                        kind              = MEM_LOAD;
                        addr              = ea;
                        o_state.pend      = MEM_LOAD;
                        o_state.pend_dest = rt;
                    end
                    OPC_SW: begin
                        kind         = MEM_STORE;
                        addr         = ea;
                        wdata        = i_rt_data;
                        o_state.pend = MEM_STORE;
                    end
                    OPC_BEQ: begin
                        if (i_rs_data == i_rt_data) begin
                            o_state.pc = br_target;
                        end
                    end
                    OPC_J: begin
                        o_state.pc = j_target;
                    end
                    default: begin
                        o_state.run = 1'b0;
                        fault       = FAULT_OPCODE;
                    end
                endcase
            end
        end else if (i_state.run && i_item.op == OP_RESPONSE && i_state.pend != MEM_NONE) begin
            if (i_state.pend == MEM_LOAD) begin
                if (i_item.access_ok) begin
                    o_wb = '{en: 1'b1, addr: i_state.pend_dest, data: i_item.data_word};
                end else begin
                    o_state.run = 1'b0;
                    fault       = FAULT_LOAD;
                end
            end else if (!i_item.access_ok) begin
                o_state.run = 1'b0;
                fault       = FAULT_STORE;
            end
            o_state.pend = MEM_NONE;
        end else begin
            // Stopped core, fetch while an access is pending, or a stray response.
        end
    end

    assign o_result = '{
        next_fetch_addr: o_state.pc,
        mem_kind:        kind,
        mem_addr:        addr,
        mem_wdata:       wdata,
        is_running:      o_state.run,
        fault_code:      fault,
        retired:         o_state.retired
    };

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for the MIPS subset instruction step core.
`timescale 1ns / 1ps

module testbench;
    import msis_pkg::*;

    // Generous bound: about 1500 items, each at worst with the longest send gap, the longest
    // receiver stall and the pipeline, plus the drain pauses, taken several times.
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned RANDOM_ITEMS = 1400;
    localparam int unsigned MAX_REPORTS  = 100;

    // The scoreboard carries its own copy of the architectural state. Every accepted item
    // advances that copy by one step, and the result that step should produce is queued
    // until the core hands its result over.
    class mips_step_tracker;
        logic [31:0]    regs [REG_COUNT_DEF];
        logic [31:0]    pc;
        logic           run;
        logic [31:0]    retired;
        logic [1:0]     pend;
        t_reg_idx       pend_dest;
        t_out_item      expected_steps [$];
        int unsigned    accepted, checked, failures, ignored;
        int unsigned    loads, stores, taken_branches, jumps;
        logic [2:0]     fault_seen;

        function new();
            foreach (regs[i]) regs[i] = '0;
            pc = '0;
            run = 1'b1;
            retired = '0;
            pend = MEM_NONE;
            pend_dest = '0;
            fault_seen = FAULT_NONE;
        endfunction

        function bit access_pending();
            return pend != MEM_NONE;
        endfunction

        function int unsigned waiting();
            return expected_steps.size();
        endfunction

        // One step of the core. A fetch is taken only while running with no access open,
        // a response only while running with an access open; everything else is ignored
        // and just reports the current state.
        function t_out_item predict_step(t_in_item it);
            t_out_item   r;
            logic [5:0]  opc, fn;
            t_reg_idx    rs, rt, rd;
            logic [31:0] sx;
            r = '0;
            opc = it.data_word[OPC_LSB +: 6];
            rs  = it.data_word[RS_LSB +: 5];
            rt  = it.data_word[RT_LSB +: 5];
            rd  = it.data_word[RD_LSB +: 5];
            fn  = it.data_word[5:0];
            sx  = {{16{it.data_word[15]}}, it.data_word[15:0]};
            if (run && it.op == OP_FETCH && pend == MEM_NONE) begin
                if (!it.access_ok) begin
                    run = 1'b0;
                    r.fault_code = FAULT_FETCH;
                end else begin
                    pc = pc + WORD_BYTES;
                    retired = retired + 1;
                    case (opc)
                        OPC_RTYPE: begin
                            if (fn == FN_ADD) begin
                                regs[rd] = regs[rs] + regs[rt];
                            end else begin
                                run = 1'b0;
                                r.fault_code = FAULT_FUNCT;
                            end
                        end
                        OPC_LW: begin
                            r.mem_kind = MEM_LOAD;
                            r.mem_addr = regs[rs] + sx;
                            pend = MEM_LOAD;
                            pend_dest = rt;
                            loads++;
                        end
                        OPC_SW: begin
                            r.mem_kind = MEM_STORE;
                            r.mem_addr = regs[rs] + sx;
                            r.mem_wdata = regs[rt];
                            pend = MEM_STORE;
                            stores++;
                        end
                        OPC_BEQ: begin
                            if (regs[rs] == regs[rt]) begin
                                pc = pc + {sx[29:0], 2'b00};
                                taken_branches++;
                            end
                        end
                        OPC_J: begin
                            pc = {pc[31:28], it.data_word[25:0], 2'b00};
                            jumps++;
                        end
                        default: begin
                            run = 1'b0;
                            r.fault_code = FAULT_OPCODE;
                        end
                    endcase
                end
            end else if (run && it.op == OP_RESPONSE && pend != MEM_NONE) begin
                if (pend == MEM_LOAD) begin
                    if (it.access_ok) begin
                        regs[pend_dest] = it.data_word;
                    end else begin
                        run = 1'b0;
                        r.fault_code = FAULT_LOAD;
                    end
                end else if (!it.access_ok) begin
                    run = 1'b0;
                    r.fault_code = FAULT_STORE;
                end
                pend = MEM_NONE;
            end else begin
                ignored++;
            end
            if (r.fault_code != FAULT_NONE) fault_seen = r.fault_code;
            r.next_fetch_addr = pc;
            r.is_running = run;
            r.retired = retired;
            return r;
        endfunction

        function void note_accepted(t_in_item it);
            accepted++;
            expected_steps.push_back(predict_step(it));
        endfunction

        task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            failures++;
            if (failures <= MAX_REPORTS) begin
                $display("MISMATCH result %0d %s: got 0x%08h, expected 0x%08h",
                         checked, what, got, want);
            end
        endtask

        task check_step(t_out_item got);
            t_out_item want;
            checked++;
            if (expected_steps.size() == 0) begin
                report_mismatch("result with no item outstanding", got.next_fetch_addr, '0);
            end else begin
                want = expected_steps.pop_front();
                if (got.next_fetch_addr !== want.next_fetch_addr)
                    report_mismatch("next_fetch_addr", got.next_fetch_addr,
                                    want.next_fetch_addr);
                if (got.mem_kind !== want.mem_kind)
                    report_mismatch("mem_kind", 32'(got.mem_kind), 32'(want.mem_kind));
                if (got.mem_addr !== want.mem_addr)
                    report_mismatch("mem_addr", got.mem_addr, want.mem_addr);
                if (got.mem_wdata !== want.mem_wdata)
                    report_mismatch("mem_wdata", got.mem_wdata, want.mem_wdata);
                if (got.is_running !== want.is_running)
                    report_mismatch("is_running", 32'(got.is_running), 32'(want.is_running));
                if (got.fault_code !== want.fault_code)
                    report_mismatch("fault_code", 32'(got.fault_code), 32'(want.fault_code));
                if (got.retired !== want.retired)
                    report_mismatch("retired", got.retired, want.retired);
            end
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    t_in_item    in_item;
    logic        out_valid;
    logic        out_stall;
    t_out_item   out_item;

    mips_step_tracker tracker;
    int unsigned send_gap_max = 0;
    int unsigned stall_max = 0;
    int unsigned cycle_count = 0;

    mips_subset_instruction_step DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    // 12 ns period.
    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Hard stop in case the core hangs or loses a result.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycle_count, tracker.waiting());
            $display("[mips_subset_instruction_step] ERROR");
            $finish;
        end
    end

    // Results are sampled at the edge where they are handed over; the values read here
    // are the ones that were stable before the edge.
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) tracker.check_step(out_item);
    end

    // Idle limits are redrawn per stretch of items: none, light or heavy, so that some
    // stretches run back to back while others leave gaps at every pipeline phase.
    function automatic int unsigned pick_gap_limit();
        int unsigned pick;
        pick = $urandom_range(2, 0);
        return (pick == 0) ? 0 : (pick == 1) ? 4 : 18;
    endfunction

    // Receiver: before each result it holds stall high for a random number of cycles,
    // then takes the result as soon as one is offered.
    initial begin : receiver
        int unsigned hold;
        out_stall = 1'b0;
        do @(posedge clk); while (!rst_n);
        forever begin
            hold = $urandom_range(stall_max, 0);
            if (hold > 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!(out_valid && !out_stall));
        end
    end

    // Called at a rising edge; returns at the edge where the item was accepted. The item is
    // handed to the scoreboard right there, so its expectation is queued before any result.
    task automatic send_item(input logic op, input logic [31:0] word, input logic ok);
        int unsigned gap;
        gap = $urandom_range(send_gap_max, 0);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= '{op: op, data_word: word, access_ok: ok};
        do @(posedge clk); while (in_stall);
        tracker.note_accepted('{op: op, data_word: word, access_ok: ok});
    endtask

    task automatic fetch(input logic [31:0] word);
        send_item(OP_FETCH, word, 1'b1);
    endtask

    task automatic respond(input logic [31:0] data, input logic ok);
        send_item(OP_RESPONSE, data, ok);
    endtask

    // Stop sending and let every outstanding result come back.
    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (tracker.waiting() != 0);
    endtask

    function automatic logic [31:0] enc_r(t_reg_idx rs, t_reg_idx rt, t_reg_idx rd,
                                          logic [4:0] shamt, logic [5:0] fn);
        return {OPC_RTYPE, rs, rt, rd, shamt, fn};
    endfunction

    function automatic logic [31:0] enc_i(logic [5:0] opc, t_reg_idx rs, t_reg_idx rt,
                                          logic [15:0] imm);
        return {opc, rs, rt, imm};
    endfunction

    // A supported instruction with random operands. Branches compare a register with
    // itself now and then, so that taken branches are frequent enough.
    function automatic logic [31:0] random_instruction();
        logic [31:0] w;
        t_reg_idx    rs, rt;
        int unsigned pick;
        w = $urandom();
        rs = w[25:21];
        if ($urandom_range(99, 0) < 30) rt = rs;
        else rt = w[20:16];
        pick = $urandom_range(99, 0);
        if (pick < 35) return enc_r(rs, rt, w[15:11], w[10:6], FN_ADD);
        else if (pick < 55) return enc_i(OPC_LW, rs, rt, w[15:0]);
        else if (pick < 75) return enc_i(OPC_SW, rs, rt, w[15:0]);
        else if (pick < 92) return enc_i(OPC_BEQ, rs, rt, w[15:0]);
        return {OPC_J, w[25:0]};
    endfunction

    initial begin : stimulus
        int unsigned effective, burst, segments, roll;
        logic [31:0] w;
        logic [5:0]  code;
        logic [2:0]  fault_pick;
        effective = 0;
        burst = 0;
        segments = 0;
        tracker = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. Load all ones and the largest positive value, then use them for
        // a wrapping add, a write of register 0, a store at the largest positive offset,
        // branches at both offset extremes and jumps to both target extremes.
        send_gap_max = pick_gap_limit();
        stall_max = pick_gap_limit();
        fetch(enc_i(OPC_LW, 5'd0, 5'd1, 16'h0000));
        respond(32'hFFFF_FFFF, 1'b1);
        fetch(enc_i(OPC_LW, 5'd1, 5'd2, 16'hFFFC));
        // A fetch while the load is open is ignored, whatever it holds.
        fetch(32'hFFFF_FFFF);
        respond(32'h7FFF_FFFF, 1'b1);
        // Responses with no access open are ignored, failed or not.
        respond(32'hFFFF_FFFF, 1'b0);
        respond(32'h0000_0000, 1'b1);
        fetch(enc_r(5'd1, 5'd2, 5'd3, 5'd0, FN_ADD));
        fetch(enc_r(5'd1, 5'd1, 5'd0, 5'h1F, FN_ADD));
        fetch(enc_i(OPC_SW, 5'd3, 5'd2, 16'h7FFF));
        respond(32'h0000_0000, 1'b1);
        fetch(enc_i(OPC_BEQ, 5'd1, 5'd1, 16'h8000));
        fetch(enc_i(OPC_BEQ, 5'd1, 5'd2, 16'h7FFF));
        fetch(enc_i(OPC_BEQ, 5'd4, 5'd5, 16'h7FFF));
        fetch({OPC_J, 26'h3FF_FFFF});
        fetch({OPC_J, 26'h000_0000});
        fetch(enc_i(OPC_LW, 5'd0, 5'd31, 16'hFFFF));
        send_item(OP_FETCH, 32'h0000_0000, 1'b0);
        respond(32'h8000_0001, 1'b1);
        fetch(enc_r(5'd31, 5'd0, 5'd30, 5'd0, FN_ADD));

        // Hold the sender until the pipeline is empty.
        wait_drained();

        // Random part: mostly well-formed programs, where every load or store is followed
        // by its response, salted with items the core has to ignore.
        while (effective < RANDOM_ITEMS) begin
            if (burst == 0) begin
                burst = 70;
                send_gap_max = pick_gap_limit();
                stall_max = pick_gap_limit();
                segments++;
                if (segments % 5 == 0) wait_drained();
            end
            burst--;
            roll = $urandom_range(99, 0);
            w = $urandom();
            if (tracker.access_pending()) begin
                if (roll < 88) begin
                    respond($urandom(), 1'b1);
                    effective++;
                end else begin
                    send_item(OP_FETCH, $urandom(), w[0]);
                end
            end else if (roll < 93) begin
                fetch(random_instruction());
                effective++;
            end else begin
                send_item(OP_RESPONSE, $urandom(), w[0]);
            end
        end

        // Any fault stops the core for good, so at most one can be seen per run. One kind
        // is drawn at random, or none at all.
        if (tracker.access_pending()) respond($urandom(), 1'b1);
        fault_pick = 3'($urandom_range(5, 0));
        w = $urandom();
        case (fault_pick)
            FAULT_FETCH: begin
                send_item(OP_FETCH, w, 1'b0);
            end
            FAULT_FUNCT: begin
                do code = 6'($urandom()); while (code == FN_ADD);
                fetch(enc_r(w[25:21], w[20:16], w[15:11], w[10:6], code));
            end
            FAULT_LOAD: begin
                fetch(enc_i(OPC_LW, w[25:21], w[20:16], w[15:0]));
                respond($urandom(), 1'b0);
            end
            FAULT_STORE: begin
                fetch(enc_i(OPC_SW, w[25:21], w[20:16], w[15:0]));
                respond($urandom(), 1'b0);
            end
            FAULT_OPCODE: begin
                do code = 6'($urandom());
                while (code inside {OPC_RTYPE, OPC_J, OPC_BEQ, OPC_LW, OPC_SW});
                fetch({code, w[25:0]});
            end
            default: begin
            end
        endcase

        // After a fault every item must be ignored; without one these simply run on.
        repeat (20) begin
            w = $urandom();
            send_item(w[0], $urandom(), w[1]);
        end

        wait_drained();
        repeat (8) @(posedge clk);
        if (tracker.waiting() != 0)
            tracker.report_mismatch("results never delivered", tracker.waiting(), 0);

        $display("Covered %0d items (%0d ignored by the core), %0d loads, %0d stores,",
                 tracker.accepted, tracker.ignored, tracker.loads, tracker.stores);
        $display("%0d taken branches, %0d jumps; stop fault code %0d; %0d mismatches.",
                 tracker.taken_branches, tracker.jumps, tracker.fault_seen,
                 tracker.failures);
        if (tracker.failures == 0) begin
            $display("[mips_subset_instruction_step] OK");
        end else begin
            $display("[mips_subset_instruction_step] ERROR");
        end
        $finish;
    end
endmodule

// ----- sim.f -----
+incdir+design
design/msis_pkg.sv
design/msis_regfile.sv
design/msis_exec.sv
design/mips_subset_instruction_step.sv
verif/testbench.sv
